[rtl/assert_macros.svh]
// Assertion macros included by the trailing_moving_average design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition at one edge leads to another at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/tma_pkg.sv]
package tma_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int WIN_W        = 7;

    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W   = (WIN_W > CNT_W) ? WIN_W : CNT_W;
    localparam int SUM_W   = SAMPLE_WIDTH + SLOT_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[rtl/tma_if.sv]
interface tma_sample_if;

    logic                                    valid;
    logic                                    ready;
    logic signed [tma_pkg::SAMPLE_WIDTH-1:0] sample;
    logic                                    start_of_series;

    modport source (output valid, output sample, output start_of_series, input ready);
    modport sink   (input valid, input sample, input start_of_series, output ready);

endinterface

interface tma_average_if;

    logic                                    valid;
    logic                                    ready;
    logic signed [tma_pkg::SAMPLE_WIDTH-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);

endinterface

[rtl/trailing_moving_average.sv]
// Channel   | Direction | Word                              | Handshake
// i_smp     | in        | sample, start_of_series           | valid/ready
// o_avg     | out       | average                           | valid/ready
// i_cfg     | in        | window_size                       | write enable only
//
// From acceptance to result, the last count entries of the ring memory, where count is the
// number of samples averaged, are read one entry per cycle into the
// accumulator, then a restoring divider produces one quotient bit per cycle.
// Reset is synchronous and active low; it empties the history and sets the window to 4.
// A new word is accepted while the previous result still waits in the output register.
// A stalled output holds the finished quotient until the output register is free.
`include "assert_macros.svh"

module trailing_moving_average (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tma_pkg::WIN_W-1:0]  i_cfg_wdata,
    tma_sample_if.sink                 i_smp,
    tma_average_if.source              o_avg
);
    import tma_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_ring [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] r_rd_data;

    t_state                   r_state, n_state;
    logic [WIN_W-1:0]         r_window;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_left, n_left;
    logic [SLOT_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic                     r_rd_vld, n_rd_vld;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic                     r_neg, n_neg;
    logic [SUM_W-1:0]         r_dvd, n_dvd;
    logic [CNT_W-1:0]         r_rem, n_rem;
    logic [STEP_W-1:0]        r_step, n_step;
    logic                     r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH-1:0]  r_avg, n_avg;

    logic                     accept;
    logic [SLOT_W-1:0]        wr_slot;
    logic [CNT_W-1:0]         base_fill;
    logic [CMP_W-1:0]         eff_window;
    logic [CMP_W-1:0]         fill_ext;
    logic [CNT_W:0]           shifted;
    logic [CNT_W:0]           divisor;
    logic [SUM_W-1:0]         quot_neg;

    assign accept      = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == ST_IDLE);
    assign o_avg.valid = r_out_valid;
    assign o_avg.average = r_avg;

    assign wr_slot   = i_smp.start_of_series ? '0 : r_slot;
    assign base_fill = i_smp.start_of_series ? '0 : r_fill;
    assign shifted   = {r_rem, r_dvd[SUM_W-1]};
    assign divisor   = {1'b0, r_count};
    assign quot_neg  = ~r_dvd + SUM_W'(1);

    always_comb begin
        priority if (r_window == '0) begin
            eff_window = CMP_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(WINDOW_MAX)) begin
            eff_window = CMP_W'(WINDOW_MAX);
        end else begin
            eff_window = CMP_W'(r_window);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_count     = r_count;
        n_left      = r_left;
        n_rd_ptr    = r_rd_ptr;
        n_rd_vld    = 1'b0;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_avg.ready;
        n_avg       = r_avg;
        fill_ext    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_slot   = (wr_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : wr_slot + SLOT_W'(1);
                    n_fill   = (base_fill < CNT_W'(WINDOW_MAX)) ? base_fill + CNT_W'(1)
                                                                : base_fill;
                    fill_ext = CMP_W'(n_fill);
                    n_count  = (eff_window > fill_ext) ? n_fill : CNT_W'(eff_window);
                    n_left   = n_count;
                    n_rd_ptr = wr_slot;
                    n_acc    = '0;
                    n_state  = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_left != '0) begin
                    n_rd_vld = 1'b1;
                    n_left   = r_left - CNT_W'(1);
                    n_rd_ptr = (r_rd_ptr == '0) ? SLOT_W'(WINDOW_MAX - 1)
                                                : r_rd_ptr - SLOT_W'(1);
                end
                if (r_rd_vld) begin
                    n_acc = r_acc + SUM_W'(r_rd_data);
                end else if (r_left == '0) begin
                    n_neg   = r_acc[SUM_W-1];
                    n_dvd   = r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);
                    n_rem   = '0;
                    n_step  = STEP_W'(SUM_W);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (shifted >= divisor) begin
                    n_rem = CNT_W'(shifted - divisor);
                    n_dvd = {r_dvd[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[CNT_W-1:0];
                    n_dvd = {r_dvd[SUM_W-2:0], 1'b0};
                end
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_avg.ready) begin
                    n_out_valid = 1'b1;
                    n_avg       = r_neg ? quot_neg[SAMPLE_WIDTH-1:0] : r_dvd[SAMPLE_WIDTH-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WIN_W'(4);
            r_slot      <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_rd_vld    <= n_rd_vld;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_rd_ptr <= n_rd_ptr;
        r_acc    <= n_acc;
        r_neg    <= n_neg;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_avg    <= n_avg;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[wr_slot] <= i_smp.sample;
        end
        r_rd_data <= r_ring[r_rd_ptr];
    end

    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= CNT_W'(WINDOW_MAX), "fill count above ring depth")
    `ASSERT_CLK(a_count_valid, i_clk, i_rst_n, (r_state != ST_SUM) || (r_count != '0 && r_count <= r_fill), "averaging count out of range")
    `ASSERT_CLK(a_rem_below, i_clk, i_rst_n, (r_state != ST_DIV) || (r_rem < r_count), "divider remainder not below divisor")
    `ASSERT_NEXT(a_accept_sum, i_clk, i_rst_n, accept, r_state == ST_SUM, "accepted word did not start summation")

endmodule
